// ===== src/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the frame sequence pacer.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int RING_FRAMES_MAX = 1024;
    localparam int SLOT_W          = 10;
    localparam int COUNT_W         = 32;
    localparam int RATE_W          = 8;
    localparam int RING_W          = 11;
    localparam int DIV_W           = RATE_W + 1;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 2;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_SIGNAL    = 3'd3,
        CMD_SET_POS   = 3'd4
    } cmd_code_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RATE_DIVIDER = 2'd0,
        REG_STOP_AFTER   = 2'd1,
        REG_SIGNAL_AT    = 2'd2,
        REG_RING_FRAMES  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic               upload_ok;
        logic [COUNT_W-1:0] new_count;
        logic [SLOT_W-1:0]  new_slot;
    } fsp_in_t;

    typedef struct packed {
        logic               frame_shown;
        logic [SLOT_W-1:0]  shown_slot;
        logic [COUNT_W-1:0] count_now;
        logic               signal_raised;
        logic               capture_start;
        logic               running;
        logic               upload_failed;
    } fsp_out_t;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_divider;
        logic [COUNT_W-1:0] stop_after_count;
        logic [COUNT_W-1:0] signal_at_count;
        logic [RING_W-1:0]  frames_in_ring;
    } fsp_cfg_t;

endpackage

// ===== src/fsp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fsp_cfg_regs
// Host-writable configuration registers of the pacer.
// ----------------------------------------------------------------------------
module fsp_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [fsp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output fsp_pkg::fsp_cfg_t               cfg
);
    import fsp_pkg::*;

    fsp_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_divider     <= '0;
            cfg_reg.stop_after_count <= '0;
            cfg_reg.signal_at_count  <= '0;
            cfg_reg.frames_in_ring   <= RING_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_RATE_DIVIDER: cfg_reg.rate_divider     <= cfg_wdata[RATE_W-1:0];
                REG_STOP_AFTER:   cfg_reg.stop_after_count <= cfg_wdata[COUNT_W-1:0];
                REG_SIGNAL_AT:    cfg_reg.signal_at_count  <= cfg_wdata[COUNT_W-1:0];
                REG_RING_FRAMES:  cfg_reg.frames_in_ring   <= cfg_wdata[RING_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/fsp_step.sv =====
// ----------------------------------------------------------------------------
// fsp_step
// Pacing state and the per-item next-state and result logic.
// ----------------------------------------------------------------------------
module fsp_step (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  fsp_pkg::fsp_in_t    item,
    input  fsp_pkg::fsp_cfg_t   cfg,
    output fsp_pkg::fsp_out_t   result
);
    import fsp_pkg::*;

    logic               run_flag_reg,       run_flag_next;
    logic               run_seen_reg,       run_seen_next;
    logic [DIV_W-1:0]   divider_left_reg,   divider_left_next;
    logic [COUNT_W-1:0] frame_count_reg,    frame_count_next;
    logic [SLOT_W-1:0]  ring_slot_reg,      ring_slot_next;
    logic               start_pending_reg,  start_pending_next;
    logic               signal_request_reg, signal_request_next;

    logic [RING_W:0]    ring_size;
    logic [RING_W:0]    slot_inc;
    logic [SLOT_W-1:0]  slot_wrapped;
    logic               rate_zero;
    logic               expired;
    logic               shown, failed, last, sig, capture;

    // ring size clamped to 1..RING_FRAMES_MAX, then wrap of the slot
    always_comb begin
        if (cfg.frames_in_ring == '0) begin
            ring_size = (RING_W+1)'(1);
        end else if (32'(cfg.frames_in_ring) > 32'(RING_FRAMES_MAX)) begin
            ring_size = (RING_W+1)'(RING_FRAMES_MAX);
        end else begin
            ring_size = {1'b0, cfg.frames_in_ring};
        end
        slot_inc     = (RING_W+1)'(ring_slot_reg) + (RING_W+1)'(1);
        slot_wrapped = (slot_inc < ring_size) ? slot_inc[SLOT_W-1:0] : '0;
    end

    assign rate_zero = (cfg.rate_divider == '0);

    always_comb begin
        run_flag_next       = run_flag_reg;
        run_seen_next       = run_seen_reg;
        divider_left_next   = divider_left_reg;
        frame_count_next    = frame_count_reg;
        ring_slot_next      = ring_slot_reg;
        start_pending_next  = start_pending_reg;
        signal_request_next = signal_request_reg;
        shown   = 1'b0;
        failed  = 1'b0;
        last    = 1'b0;
        sig     = 1'b0;
        capture = 1'b0;
        expired = 1'b0;

        unique case (item.cmd)
            CMD_START:  run_flag_next = 1'b1;
            CMD_STOP:   run_flag_next = 1'b0;
            CMD_SIGNAL: signal_request_next = 1'b1;
            CMD_SET_POS: begin
                frame_count_next = item.new_count;
                ring_slot_next   = item.new_slot;
            end
            CMD_TICK: begin
                // rising run edge: show at once, capture start at frame zero
                if (run_flag_reg != run_seen_reg) begin
                    if (run_flag_reg) begin
                        divider_left_next = '0;
                        if (frame_count_reg == '0) start_pending_next = 1'b1;
                    end
                    run_seen_next = run_flag_reg;
                end
                if (run_flag_reg) begin
                    expired = (divider_left_next == '0) || divider_left_next[DIV_W-1];
                    if (expired || rate_zero) begin
                        if (!rate_zero && frame_count_reg >= cfg.stop_after_count) begin
                            last = 1'b1;
                        end else if (item.upload_ok) begin
                            shown = 1'b1;
                        end else begin
                            failed = 1'b1;
                        end
                        if (!failed) begin
                            divider_left_next = {1'b0, cfg.rate_divider} - DIV_W'(1);
                        end
                    end else begin
                        divider_left_next = divider_left_next - DIV_W'(1);
                    end
                end
                if (!failed) begin
                    capture            = start_pending_next;
                    start_pending_next = 1'b0;
                    if (shown) begin
                        frame_count_next = frame_count_reg + COUNT_W'(1);
                        ring_slot_next   = slot_wrapped;
                        if (rate_zero) last = 1'b1;
                    end
                    if (last || signal_request_reg
                        || (cfg.signal_at_count != '0
                            && frame_count_next == cfg.signal_at_count)) begin
                        sig                 = 1'b1;
                        signal_request_next = 1'b0;
                    end
                    if (last) run_flag_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        result.frame_shown   = shown;
        result.shown_slot    = shown ? ring_slot_reg : '0;
        result.count_now     = frame_count_next;
        result.signal_raised = sig;
        result.capture_start = capture;
        result.running       = run_flag_next;
        result.upload_failed = failed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_flag_reg       <= 1'b0;
            run_seen_reg       <= 1'b0;
            divider_left_reg   <= '0;
            frame_count_reg    <= '0;
            ring_slot_reg      <= '0;
            start_pending_reg  <= 1'b0;
            signal_request_reg <= 1'b0;
        end else if (advance) begin
            run_flag_reg       <= run_flag_next;
            run_seen_reg       <= run_seen_next;
            divider_left_reg   <= divider_left_next;
            frame_count_reg    <= frame_count_next;
            ring_slot_reg      <= ring_slot_next;
            start_pending_reg  <= start_pending_next;
            signal_request_reg <= signal_request_next;
        end
    end

endmodule

// ===== src/frame_sequence_pacer.sv =====
// Path: an accepted item is held in the input register, passes once through the step
// logic and is registered in the result register. Throughput: one item per cycle while
// m_ready allows; a held result stalls the input register and drops s_ready.
// Reset: aresetn synchronous, active low; clears run state, frame count,
// ring slot and configuration (ring size 1). No clearing pass.
// ----------------------------------------------------------------------------
// frame_sequence_pacer
// Paces frames out of a ring of frame buffers, one display refresh per tick.
// ----------------------------------------------------------------------------
module frame_sequence_pacer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fsp_pkg::fsp_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fsp_pkg::fsp_out_t               m_data,
    input  logic                            cfg_we,
    input  logic [fsp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import fsp_pkg::*;

    fsp_cfg_t cfg;
    fsp_in_t  in_reg;
    logic     in_valid_reg;
    fsp_out_t result;
    fsp_out_t out_reg;
    logic     out_valid_reg;
    logic     advance;

    // item moves into the result register when that register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fsp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fsp_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_shown_xor_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.frame_shown && m_data.upload_failed))
        else $error("frame shown and upload failed in one item");

    a_slot_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.frame_shown) |-> (m_data.shown_slot == '0))
        else $error("shown_slot nonzero without a shown frame");

    a_fail_keeps_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.upload_failed) |-> m_data.running)
        else $error("upload failure ended the run");

    a_no_result_from_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

// ===== test/tb_frame_sequence_pacer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_sequence_pacer
// Self-checking bench for the frame sequence pacer. A short directed table
// covers reset behaviour, unused command codes, upload failure, single-frame
// mode, count wrap and slot wrap. Random phases follow under changing
// register settings. Every result is checked against a local model of the
// pacing logic, or for typed rows against the table's expected result. Both
// handshakes idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_frame_sequence_pacer;
    import fsp_pkg::*;

    localparam logic [2:0]  CMD_UNUSED_LO   = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI   = 3'd7;
    localparam int          PHASES          = 13;
    localparam int          ITEMS_PER_PHASE = 102;
    localparam int          PRESSURE_PHASE  = 5;
    localparam int          RX_HOLD_CYCLES  = 80;
    localparam int          DRAIN_SETTLE    = 4;
    localparam int          END_SETTLE      = 8;
    localparam int          STALL_LIMIT     = 2000;

    typedef struct {
        logic     is_cfg;
        fsp_cfg_t cfg;
        fsp_in_t  item;
        logic     typed;
        fsp_out_t want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    fsp_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    fsp_out_t              m_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // local copy of the pacer state and registers
    logic                  run_on       = 1'b0;
    logic                  run_was      = 1'b0;
    logic [DIV_W-1:0]      tick_div     = '0;
    logic [COUNT_W-1:0]    frames_done  = '0;
    logic [SLOT_W-1:0]     slot_now     = '0;
    logic                  capture_due  = 1'b0;
    logic                  signal_due   = 1'b0;
    logic [RATE_W-1:0]     cfg_rate     = '0;
    logic [COUNT_W-1:0]    cfg_stop_at  = '0;
    logic [COUNT_W-1:0]    cfg_signal_at = '0;
    logic [RING_W-1:0]     cfg_ring     = 11'd1;

    fsp_out_t              pending_results[$];
    plan_row_t             plan[$];
    int unsigned           idle_pct     = 0;
    logic                  hold_off_req = 1'b0;
    int unsigned           error_count  = 0;
    int unsigned           result_idx   = 0;
    int unsigned           quiet_cycles = 0;

    frame_sequence_pacer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // one item through the pacer: updates local state, returns the result
    task automatic pace_step(input fsp_in_t it, output fsp_out_t res);
        logic             shown;
        logic             failed;
        logic             last;
        logic             expired;
        logic [RING_W-1:0] ring_sz;
        logic [RING_W-1:0] slot_inc;
        res    = '0;
        shown  = 1'b0;
        failed = 1'b0;
        last   = 1'b0;
        case (it.cmd)
            CMD_START:   run_on = 1'b1;
            CMD_STOP:    run_on = 1'b0;
            CMD_SIGNAL:  signal_due = 1'b1;
            CMD_SET_POS: begin
                frames_done = it.new_count;
                slot_now    = it.new_slot;
            end
            CMD_TICK: begin
                if (run_on != run_was) begin
                    // rising run edge: next frame at once
                    if (run_on) begin
                        tick_div = '0;
                        if (frames_done == '0)
                            capture_due = 1'b1;
                    end
                    run_was = run_on;
                end
                if (run_on) begin
                    expired = (tick_div == '0) || tick_div[DIV_W-1];
                    if (expired || cfg_rate == '0) begin
                        if (cfg_rate != '0 && frames_done >= cfg_stop_at)
                            last = 1'b1;
                        else if (it.upload_ok)
                            shown = 1'b1;
                        else
                            failed = 1'b1;
                        // failed load keeps the divider expired for a retry
                        if (!failed)
                            tick_div = {1'b0, cfg_rate} - 9'd1;
                    end else begin
                        tick_div = tick_div - 9'd1;
                    end
                end
                if (!failed) begin
                    res.capture_start = capture_due;
                    capture_due = 1'b0;
                    if (shown) begin
                        res.frame_shown = 1'b1;
                        res.shown_slot  = slot_now;
                        frames_done     = frames_done + 32'd1;
                        if (cfg_ring == '0)
                            ring_sz = 11'd1;
                        else if (cfg_ring > RING_FRAMES_MAX)
                            ring_sz = RING_W'(RING_FRAMES_MAX);
                        else
                            ring_sz = cfg_ring;
                        slot_inc = {1'b0, slot_now} + 11'd1;
                        slot_now = (slot_inc < ring_sz) ? slot_inc[SLOT_W-1:0] : '0;
                        if (cfg_rate == '0)
                            last = 1'b1;
                    end
                    if (last || (cfg_signal_at != '0 && frames_done == cfg_signal_at)
                            || signal_due) begin
                        res.signal_raised = 1'b1;
                        signal_due = 1'b0;
                    end
                    if (last)
                        run_on = 1'b0;
                end
            end
            default: ;
        endcase
        res.count_now     = frames_done;
        res.running       = run_on;
        res.upload_failed = failed;
    endtask

    function automatic fsp_out_t host_res(input logic [COUNT_W-1:0] count, input logic run,
                                          input logic failed);
        fsp_out_t r;
        r               = '0;
        r.count_now     = count;
        r.running       = run;
        r.upload_failed = failed;
        return r;
    endfunction

    task automatic plan_item(input logic [2:0] cmd, input logic ok,
                             input logic [COUNT_W-1:0] count, input logic [SLOT_W-1:0] slot,
                             input logic typed, input fsp_out_t want);
        plan_row_t row;
        row                = '{default: '0};
        row.item.cmd       = cmd;
        row.item.upload_ok = ok;
        row.item.new_count = count;
        row.item.new_slot  = slot;
        row.typed          = typed;
        row.want           = want;
        plan.push_back(row);
    endtask

    task automatic plan_cfg(input logic [RATE_W-1:0] rate, input logic [COUNT_W-1:0] stop_at,
                            input logic [COUNT_W-1:0] sig_at, input logic [RING_W-1:0] ring);
        plan_row_t row;
        row                      = '{default: '0};
        row.is_cfg               = 1'b1;
        row.cfg.rate_divider     = rate;
        row.cfg.stop_after_count = stop_at;
        row.cfg.signal_at_count  = sig_at;
        row.cfg.frames_in_ring   = ring;
        plan.push_back(row);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR: result %0d %s: got %h, expected %h", result_idx, field, got, want);
        error_count++;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    // sender must already have dropped s_valid
    task automatic set_config(input logic [31:0] rate_w, input logic [31:0] stop_w,
                              input logic [31:0] sig_w, input logic [31:0] ring_w);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_RATE_DIVIDER;
        cfg_wdata <= rate_w;
        @(posedge aclk);
        cfg_addr  <= REG_STOP_AFTER;
        cfg_wdata <= stop_w;
        @(posedge aclk);
        cfg_addr  <= REG_SIGNAL_AT;
        cfg_wdata <= sig_w;
        @(posedge aclk);
        cfg_addr  <= REG_RING_FRAMES;
        cfg_wdata <= ring_w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_rate      = rate_w[RATE_W-1:0];
        cfg_stop_at   = stop_w;
        cfg_signal_at = sig_w;
        cfg_ring      = ring_w[RING_W-1:0];
    endtask

    task automatic send_item(input fsp_in_t it, input logic typed, input fsp_out_t want);
        fsp_out_t    predicted;
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pace_step(it, predicted);
        pending_results.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic fsp_in_t random_item();
        fsp_in_t     it;
        int unsigned pick;
        pick         = $urandom_range(99);
        it.upload_ok = ($urandom_range(9) != 0);
        it.new_count = $urandom();
        it.new_slot  = SLOT_W'($urandom());
        if (pick < 68) begin
            it.cmd = CMD_TICK;
        end else if (pick < 78) begin
            it.cmd = CMD_START;
        end else if (pick < 82) begin
            it.cmd = CMD_STOP;
        end else if (pick < 88) begin
            it.cmd = CMD_SIGNAL;
        end else if (pick < 96) begin
            it.cmd = CMD_SET_POS;
            // small counts reach the stop and signal points, high ones wrap
            case ($urandom_range(3))
                0:       it.new_count = $urandom_range(24);
                1:       it.new_count = 32'hFFFF_FFFF - $urandom_range(6);
                default: ;
            endcase
            if ($urandom_range(1) == 0)
                it.new_slot = SLOT_W'($urandom_range(12));
        end else begin
            it.cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        end
        return it;
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        fsp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_data.count_now, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.frame_shown !== want.frame_shown)
                    report_mismatch("frame_shown", 32'(m_data.frame_shown),
                                    32'(want.frame_shown));
                if (m_data.shown_slot !== want.shown_slot)
                    report_mismatch("shown_slot", 32'(m_data.shown_slot),
                                    32'(want.shown_slot));
                if (m_data.count_now !== want.count_now)
                    report_mismatch("count_now", m_data.count_now, want.count_now);
                if (m_data.signal_raised !== want.signal_raised)
                    report_mismatch("signal_raised", 32'(m_data.signal_raised),
                                    32'(want.signal_raised));
                if (m_data.capture_start !== want.capture_start)
                    report_mismatch("capture_start", 32'(m_data.capture_start),
                                    32'(want.capture_start));
                if (m_data.running !== want.running)
                    report_mismatch("running", 32'(m_data.running), 32'(want.running));
                if (m_data.upload_failed !== want.upload_failed)
                    report_mismatch("upload_failed", 32'(m_data.upload_failed),
                                    32'(want.upload_failed));
            end
            result_idx++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_frame_sequence_pacer: FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] rate_w;
        logic [31:0] stop_w;
        logic [31:0] sig_w;
        logic [31:0] ring_w;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_RATE_DIVIDER;
        cfg_wdata <= '0;

        // reset registers: single-frame mode, ring of one
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b1, host_res('0, 1'b0, 1'b0));
        plan_item(CMD_UNUSED_LO, 1'b1, '1, '1, 1'b1, host_res('0, 1'b0, 1'b0));
        plan_item(CMD_UNUSED_HI, 1'b0, '0, '0, 1'b1, host_res('0, 1'b0, 1'b0));
        plan_item(CMD_START,     1'b0, '0, '0, 1'b1, host_res('0, 1'b1, 1'b0));
        // failed load skips capture; retried on the next tick
        plan_item(CMD_TICK,      1'b0, '0, '0, 1'b1, host_res('0, 1'b1, 1'b1));
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_SIGNAL,    1'b0, '0, '0, 1'b1, host_res(32'd1, 1'b0, 1'b0));
        plan_item(CMD_TICK,      1'b0, '0, '0, 1'b0, '0);
        plan_item(CMD_SET_POS,   1'b1, 32'hFFFF_FFFF, 10'd1023, 1'b1,
                  host_res(32'hFFFF_FFFF, 1'b0, 1'b0));
        plan_item(CMD_START,     1'b1, '0, '0, 1'b1, host_res(32'hFFFF_FFFF, 1'b1, 1'b0));
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_SET_POS,   1'b0, '0, '0, 1'b1, host_res('0, 1'b0, 1'b0));
        // paced run, ring of three, stop at three frames
        plan_cfg(8'd2, 32'd3, 32'd2, 11'd3);
        plan_item(CMD_START,     1'b1, '0, '0, 1'b1, host_res('0, 1'b1, 1'b0));
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_TICK,      1'b0, '0, '0, 1'b0, '0);
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        // slot beyond the ring wraps to zero on the next advance
        plan_item(CMD_SET_POS,   1'b1, 32'd1, 10'd700, 1'b0, '0);
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_TICK,      1'b1, '0, '0, 1'b0, '0);
        plan_item(CMD_STOP,      1'b1, '0, '0, 1'b0, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        idle_pct = 30;
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                s_valid <= 1'b0;
                set_config(32'(plan[i].cfg.rate_divider), plan[i].cfg.stop_after_count,
                           plan[i].cfg.signal_at_count, 32'(plan[i].cfg.frames_in_ring));
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            s_valid <= 1'b0;
            case (ph)
                0: begin
                    rate_w = 32'd255;
                    stop_w = '1;
                    sig_w  = '1;
                    ring_w = 32'd2047;
                end
                1: begin
                    rate_w = '0;
                    stop_w = '0;
                    sig_w  = '0;
                    ring_w = '0;
                end
                2: begin
                    rate_w = 32'd1;
                    stop_w = 32'd40;
                    sig_w  = 32'd5;
                    ring_w = RING_FRAMES_MAX;
                end
                default: begin
                    rate_w = ($urandom() & 32'hFFFF_FF00)
                           | (($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4));
                    stop_w = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(40);
                    case ($urandom_range(3))
                        0:       sig_w = '0;
                        1:       sig_w = $urandom();
                        default: sig_w = $urandom_range(30);
                    endcase
                    ring_w = ($urandom() & 32'hFFFF_F800)
                           | (($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(8));
                end
            endcase
            set_config(rate_w, stop_w, sig_w, ring_w);
            case ($urandom_range(2))
                0:       idle_pct = 0;
                1:       idle_pct = 20;
                default: idle_pct = 50;
            endcase
            // sender keeps offering while the receiver holds off
            if (ph == PRESSURE_PHASE) begin
                idle_pct     = 0;
                hold_off_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (END_SETTLE) @(posedge aclk);
        if (error_count == 0)
            $display("tb_frame_sequence_pacer: PASS");
        else
            $display("tb_frame_sequence_pacer: FAIL");
        $finish;
    end

endmodule
